// ===== rtl/sst_pkg.sv =====
// Shared definitions for the string split tokenizer.
// Holds parameter defaults, configuration register indexes and the queue push type.
// No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int MAX_DELIM_DEF = 8;
  localparam int POS_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int DLEN_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPLIT_MODE   = 2'd0,
    CFG_DROP_EMPTY   = 2'd1,
    CFG_DELIM_BYTES  = 2'd2,
    CFG_DELIM_LENGTH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ===== rtl/sst_out_queue.sv =====
// Result queue for the string split tokenizer: takes up to two entries per cycle,
// hands out one entry per transaction on the output stream.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_out_queue #(
  parameter int Width = 52,
  parameter int Depth = sst_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sst_pkg::push_t             push_i,
  input  logic [Width-1:0]           wdata_a_i,
  input  logic [Width-1:0]           wdata_b_i,
  output logic                       space_o,
  output logic                       rvalid_o,
  input  logic                       rready_i,
  output logic [Width-1:0]           rdata_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int LvlW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, wptr_b;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic             pop;
  logic [LvlW-1:0]  n_push;

  assign pop      = rvalid_o && rready_i;
  assign rvalid_o = (level_q != '0);
  assign rdata_o  = mem_q[rptr_q];
  assign space_o  = (level_q <= LvlW'(Depth - 2));
  assign level_o  = level_q;
  assign wptr_b   = push_i.first ? wptr_q + PtrW'(1) : wptr_q;
  assign n_push   = LvlW'(push_i.first) + LvlW'(push_i.second);

  always_comb begin
    wptr_d  = wptr_q + PtrW'(n_push);
    rptr_d  = pop ? rptr_q + PtrW'(1) : rptr_q;
    level_d = level_q + n_push - LvlW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wptr_q] <= wdata_a_i;
    end
    if (push_i.second) begin
      mem_q[wptr_b] <= wdata_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

endmodule

// ===== rtl/string_split_tokenizer.sv =====
// Top level of the string split tokenizer: delimiter matching, field tracking
// and the result queue. Depends on sst_pkg and sst_out_queue.
//
//  Channel  Direction  Signals                 Contents
//  s_axis   in         tdata, tlast, tuser     byte, last byte, empty string mark
//  m_axis   out        tdata, tlast, tuser     start/length/count, end of string,
//                                              present/too long
//  cfg      in         cfg_we_i, cfg_idx_i     register write, no read-back
//
// One byte is taken per cycle while the queue has room; the match and field logic
// settles in the cycle of acceptance and writes its results into a four-entry queue.
// A byte that closes a field and ends the string yields two results, which leave one
// per output transaction; s_axis_tready_o is high while two or more queue entries are free.
// Reset clears all control state at once; there is no clearing pass.
// A stalled output side holds the queue and, once it fills, the input side.
`timescale 1ns / 1ps

module string_split_tokenizer #(
  parameter int MAX_DELIM = sst_pkg::MAX_DELIM_DEF,
  parameter int POS_WIDTH = sst_pkg::POS_WIDTH_DEF,
  localparam int OutDataW = ((3 * POS_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // data_byte
  input  logic                          s_axis_tlast_i,   // last_byte
  input  logic                          s_axis_tuser_i,   // empty_string
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [OutDataW-1:0]           m_axis_tdata_o,   // field_start, field_length,
                                                          // field_count, zero fill
  output logic                          m_axis_tlast_o,   // end_of_string
  output logic [1:0]                    m_axis_tuser_o,   // field_present, too_long
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sst_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int PW      = POS_WIDTH;
  localparam int CW      = POS_WIDTH + 1;
  localparam int DW      = sst_pkg::DLEN_W;
  localparam int WinD    = (MAX_DELIM > 1) ? MAX_DELIM - 1 : 1;
  localparam int WinIdxW = (WinD > 1) ? $clog2(WinD) : 1;
  localparam int BlkW    = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam int EntW    = 3 * POS_WIDTH + 4;
  localparam int QLvlW   = $clog2(sst_pkg::QUEUE_DEPTH + 1);

  // Configuration registers.
  logic                          split_mode_q;
  logic                          drop_empty_q;
  logic [sst_pkg::CFG_DATA_W-1:0] delim_q;
  logic [DW-1:0]                 delim_len_q;

  // String state.
  logic [7:0]    win_q [WinD];
  logic [7:0]    win_d [WinD];
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] fstart_q, fstart_d;
  logic [BlkW-1:0] blk_q, blk_d, blk_next;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;

  logic          in_fire;
  logic [DW-1:0] dl;
  logic [PW:0]   p_inc;
  logic [PW-1:0] pos_sat;
  logic          ovf_now;
  logic          set_hit, sub_eq, len_ok;
  logic          hit, hit_sub;
  logic [PW:0]   mstart;
  logic [PW-1:0] len1, len2, fstart_after;
  logic          keep1, keep2;
  logic [CW-1:0] cnt1, cnt2;
  logic [EntW-1:0] r1, r2, re, ent_a, ent_b, ent_out;
  sst_pkg::push_t push;
  logic          q_space;
  logic [QLvlW-1:0] q_level;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign dl      = (delim_len_q > DW'(MAX_DELIM)) ? DW'(MAX_DELIM) : delim_len_q;
  assign p_inc   = {1'b0, pos_q} + (PW+1)'(1);
  assign pos_sat = p_inc[PW] ? '1 : p_inc[PW-1:0];
  assign ovf_now = ovf_q || (pos_q == '1);
  assign len_ok  = (p_inc >= (PW+1)'(dl));

  always_comb begin
    logic [DW-1:0] idx;
    logic [DW-1:0] dl_m1;
    set_hit = 1'b0;
    dl_m1   = dl - DW'(1);
    idx     = '0;
    for (int k = 0; k < MAX_DELIM; k++) begin
      if ((DW'(k) < dl) && (delim_q[8*k +: 8] == s_axis_tdata_i)) begin
        set_hit = 1'b1;
      end
    end
    sub_eq = (delim_q[{dl_m1[2:0], 3'b000} +: 8] == s_axis_tdata_i);
    for (int k = 0; k < MAX_DELIM - 1; k++) begin
      idx = dl - DW'(2) - DW'(k);
      if ((DW'(k + 1) < dl) && (delim_q[8*k +: 8] != win_q[idx[WinIdxW-1:0]])) begin
        sub_eq = 1'b0;
      end
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_sub  = 1'b0;
    blk_next = blk_q;
    if (blk_q != '0) begin
      blk_next = blk_q - BlkW'(1);
    end else if (dl != '0) begin
      if (split_mode_q) begin
        hit = set_hit;
      end else if (len_ok && sub_eq) begin
        hit      = 1'b1;
        hit_sub  = 1'b1;
        blk_next = BlkW'(dl - DW'(1));
      end
    end
  end

  always_comb begin
    mstart       = hit_sub ? p_inc - (PW+1)'(dl) : {1'b0, pos_q};
    len1         = (mstart[PW-1:0] > fstart_q) ? mstart[PW-1:0] - fstart_q : '0;
    keep1        = hit && !(drop_empty_q && (len1 == '0));
    cnt1         = (keep1 && (cnt_q != '1)) ? cnt_q + CW'(1) : cnt_q;
    fstart_after = hit ? pos_sat : fstart_q;
    len2         = (pos_sat > fstart_after) ? pos_sat - fstart_after : '0;
    keep2        = !(drop_empty_q && (len2 == '0));
    cnt2         = (keep2 && (cnt1 != '1)) ? cnt1 + CW'(1) : cnt1;

    // Entry layout from the top: too_long, end_of_string, field_present, count,
    // length, start.
    r1 = {ovf_now, 1'b0, 1'b1, CW'(0), len1, fstart_q};
    if (keep2) begin
      r2 = {ovf_now, 1'b1, 1'b1, cnt2, len2, fstart_after};
    end else begin
      r2 = {ovf_now, 1'b1, 1'b0, cnt2, PW'(0), PW'(0)};
    end
    if (drop_empty_q) begin
      re = {1'b0, 1'b1, 1'b0, CW'(0), PW'(0), PW'(0)};
    end else begin
      re = {1'b0, 1'b1, 1'b1, CW'(1), PW'(0), PW'(0)};
    end
  end

  always_comb begin
    push  = '0;
    ent_a = r2;
    ent_b = r2;
    if (in_fire) begin
      if (s_axis_tuser_i) begin
        ent_a      = re;
        push.first = 1'b1;
      end else if (keep1) begin
        ent_a       = r1;
        push.first  = 1'b1;
        push.second = s_axis_tlast_i;
      end else begin
        push.first = s_axis_tlast_i;
      end
    end
  end

  always_comb begin
    pos_d    = pos_q;
    fstart_d = fstart_q;
    blk_d    = blk_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    win_d    = win_q;
    if (in_fire) begin
      if (s_axis_tuser_i || s_axis_tlast_i) begin
        pos_d    = '0;
        fstart_d = '0;
        blk_d    = '0;
        cnt_d    = '0;
        ovf_d    = 1'b0;
      end else begin
        pos_d    = pos_sat;
        fstart_d = fstart_after;
        blk_d    = blk_next;
        cnt_d    = cnt1;
        ovf_d    = ovf_now;
      end
      win_d[0] = s_axis_tdata_i;
      for (int j = 1; j < WinD; j++) begin
        win_d[j] = win_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fstart_q <= '0;
      blk_q    <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      fstart_q <= fstart_d;
      blk_q    <= blk_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_mode_q <= 1'b0;
      drop_empty_q <= 1'b0;
      delim_q      <= '0;
      delim_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (sst_pkg::cfg_reg_e'(cfg_idx_i))
        sst_pkg::CFG_SPLIT_MODE: begin
          split_mode_q <= cfg_wdata_i[0];
        end
        sst_pkg::CFG_DROP_EMPTY: begin
          drop_empty_q <= cfg_wdata_i[0];
        end
        sst_pkg::CFG_DELIM_BYTES: begin
          delim_q <= cfg_wdata_i;
        end
        sst_pkg::CFG_DELIM_LENGTH: begin
          delim_len_q <= cfg_wdata_i[DW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sst_out_queue #(
    .Width(EntW),
    .Depth(sst_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_a_i(ent_a),
    .wdata_b_i(ent_b),
    .space_o  (q_space),
    .rvalid_o (m_axis_tvalid_o),
    .rready_i (m_axis_tready_i),
    .rdata_o  (ent_out),
    .level_o  (q_level)
  );

  assign s_axis_tready_o = q_space;
  assign m_axis_tdata_o  = OutDataW'(ent_out[3*PW:0]);
  assign m_axis_tlast_o  = ent_out[3*PW+2];
  assign m_axis_tuser_o  = {ent_out[3*PW+3], ent_out[3*PW+1]};

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= QLvlW'(sst_pkg::QUEUE_DEPTH))
    else $error("result queue level above its depth");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tlast_i || s_axis_tuser_i)) |=> (pos_q == '0 && cnt_q == '0))
    else $error("string state not cleared after the end of a string");

  a_start_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstart_q <= pos_q)
    else $error("open field starts beyond the current position");

  a_block_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_q != '0) |-> (!split_mode_q || $past(blk_q) != '0 || $past(cfg_we_i)
                       || $past(!rst_ni)))
    else $error("overlap block set by a separator match");

endmodule
